FILE: rtl/pwpc_pkg.sv
// Shared types, constants and helpers for the pulse width and period capture block.
package pwpc_pkg;

   localparam int TIME_BITS           = 48;
   localparam int MICROS_PER_SEC      = 1_000_000;
   localparam logic [31:0] STALE_TIMEOUT_RESET = 32'(4 * MICROS_PER_SEC);
   localparam logic [TIME_BITS-1:0] SAT_LIMIT  = TIME_BITS'(64'hFFFF_FFFF);

   typedef enum logic [1:0] {
      REQ_RISE  = 2'd0,
      REQ_FALL  = 2'd1,
      REQ_TRIG  = 2'd2,
      REQ_QUERY = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type req_type;
      logic [47:0]  timestamp_us;
      logic [15:0]  revolution_count;
      logic [7:0]   trigger_index;
   } req_item_type;

   typedef struct packed {
      logic [31:0] low_width_us;
      logic [31:0] high_width_us;
      logic [31:0] period_us;
      logic [31:0] total_on_prev_cycle_us;
      logic [31:0] wave_offset_us;
      logic [31:0] cycle_duration_us;
      logic [31:0] event_count;
      logic        signal_stale;
   } rsp_item_type;

   function automatic logic [31:0] sat32(input logic [TIME_BITS-1:0] v);
      logic [31:0] r;
      r = (v > SAT_LIMIT) ? 32'hFFFF_FFFF : v[31:0];
      return r;
   endfunction

endpackage

FILE: rtl/pwpc_in_reg.sv
// Input register stage holding one accepted request item.
module pwpc_in_reg
   import pwpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  req_item_type req_item,
   output logic         req_stall,
   input  logic         advance,
   output logic         s1_valid,
   output req_item_type s1_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign take      = !valid_ff || advance;
   assign req_stall = !take;
   assign valid_in  = take ? req_valid : valid_ff;
   assign s1_valid  = valid_ff;
   assign s1_item   = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule

FILE: rtl/pwpc_meas.sv
// Measurement state and single-pass update logic for one item.
module pwpc_meas
   import pwpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_item_type item,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata,
   output rsp_item_type result
);

   logic [31:0]          timeout_ff;
   logic [TIME_BITS-1:0] last_rise_ff, last_rise_in;
   logic [TIME_BITS-1:0] last_fall_ff, last_fall_in;
   logic [31:0]          low_width_ff, low_width_in;
   logic [31:0]          high_width_ff, high_width_in;
   logic [31:0]          period_ff, period_in;
   logic [31:0]          acc_ff, acc_in;
   logic [31:0]          prev_total_ff, prev_total_in;
   logic [15:0]          seen_rev_ff, seen_rev_in;
   logic [31:0]          offset_ff, offset_in;
   logic [TIME_BITS-1:0] cycle_start_ff, cycle_start_in;
   logic [31:0]          cycle_dur_ff, cycle_dur_in;
   logic [31:0]          edge_count_ff, edge_count_in;
   logic [TIME_BITS-1:0] activity_ff, activity_in;

   logic [TIME_BITS-1:0] now;
   logic [31:0]          since_rise;
   logic [32:0]          acc_sum;
   logic [31:0]          acc_sat;
   logic [TIME_BITS-1:0] idle_time;

   assign now        = TIME_BITS'(item.timestamp_us);
   assign since_rise = sat32(now - last_rise_ff);
   assign acc_sum    = {1'b0, acc_ff} + {1'b0, since_rise};
   assign acc_sat    = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];

   always_comb begin
      last_rise_in   = last_rise_ff;
      last_fall_in   = last_fall_ff;
      low_width_in   = low_width_ff;
      high_width_in  = high_width_ff;
      period_in      = period_ff;
      acc_in         = acc_ff;
      prev_total_in  = prev_total_ff;
      seen_rev_in    = seen_rev_ff;
      offset_in      = offset_ff;
      cycle_start_in = cycle_start_ff;
      cycle_dur_in   = cycle_dur_ff;
      edge_count_in  = edge_count_ff;
      activity_in    = activity_ff;
      unique case (item.req_type)
         REQ_RISE: begin
            edge_count_in = edge_count_ff + 32'd1;
            activity_in   = now;
            low_width_in  = sat32(now - last_fall_ff);
            period_in     = since_rise;
            last_rise_in  = now;
         end
         REQ_FALL: begin
            edge_count_in = edge_count_ff + 32'd1;
            activity_in   = now;
            high_width_in = since_rise;
            acc_in        = acc_sat;
            if (seen_rev_ff != item.revolution_count) begin
               seen_rev_in   = item.revolution_count;
               prev_total_in = acc_sat;
               acc_in        = 32'd0;
               offset_in     = sat32(now - cycle_start_ff);
            end
            last_fall_in = now;
         end
         REQ_TRIG: begin
            if (item.trigger_index == 8'd0) begin
               cycle_dur_in   = sat32(now - cycle_start_ff);
               cycle_start_in = now;
            end
         end
         REQ_QUERY: begin
         end
         default: begin
         end
      endcase
   end

   assign idle_time = now - activity_in;

   always_comb begin
      result.low_width_us           = low_width_in;
      result.high_width_us          = high_width_in;
      result.period_us              = period_in;
      result.total_on_prev_cycle_us = prev_total_in;
      result.wave_offset_us         = offset_in;
      result.cycle_duration_us      = cycle_dur_in;
      result.event_count            = edge_count_in;
      result.signal_stale           = idle_time > TIME_BITS'(timeout_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= STALE_TIMEOUT_RESET;
      end else if (csr_we) begin
         timeout_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_rise_ff   <= '0;
         last_fall_ff   <= '0;
         low_width_ff   <= '0;
         high_width_ff  <= '0;
         period_ff      <= '0;
         acc_ff         <= '0;
         prev_total_ff  <= '0;
         seen_rev_ff    <= '0;
         offset_ff      <= '0;
         cycle_start_ff <= '0;
         cycle_dur_ff   <= '0;
         edge_count_ff  <= '0;
         activity_ff    <= '0;
      end else if (fire) begin
         last_rise_ff   <= last_rise_in;
         last_fall_ff   <= last_fall_in;
         low_width_ff   <= low_width_in;
         high_width_ff  <= high_width_in;
         period_ff      <= period_in;
         acc_ff         <= acc_in;
         prev_total_ff  <= prev_total_in;
         seen_rev_ff    <= seen_rev_in;
         offset_ff      <= offset_in;
         cycle_start_ff <= cycle_start_in;
         cycle_dur_ff   <= cycle_dur_in;
         edge_count_ff  <= edge_count_in;
         activity_ff    <= activity_in;
      end
   end

endmodule

FILE: rtl/pwpc_out_reg.sv
// Result register stage driving the response channel.
module pwpc_out_reg
   import pwpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         s1_valid,
   input  rsp_item_type result,
   output logic         advance,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         rsp_stall
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign advance   = !valid_ff || !rsp_stall;
   assign valid_in  = advance ? s1_valid : valid_ff;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid) begin
         item_ff <= result;
      end
   end

endmodule

FILE: rtl/pulse_width_period_capture_core.sv
// Pulse width and period capture core: top level.
// Throughput: 1 item per cycle unless rsp_stall holds the output; items pass the input register,
// then all measurement state updates in one pass and the result goes to the output register.
// Reset: synchronous, active high; clears all measurements, empties both stages and
// loads the stale timeout with 4000000 us.
module pulse_width_period_capture_core
   import pwpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);

   logic         advance;
   logic         s1_valid;
   req_item_type s1_item;
   rsp_item_type result;

   pwpc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .req_stall (req_stall),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item)
   );

   pwpc_meas u_meas (
      .clock     (clock),
      .reset     (reset),
      .fire      (s1_valid && advance),
      .item      (s1_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   pwpc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_stall (rsp_stall)
   );

endmodule

FILE: tb/pulse_width_period_capture_core_test.sv
// Self-checking testbench for the pulse width and period capture core.
`timescale 1ns / 100ps

module pulse_width_period_capture_core_test;
   import pwpc_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam logic [31:0] TIMEOUT_AT_RESET = 32'd4_000_000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;
   logic         csr_we;
   logic [31:0]  csr_wdata;

   pulse_width_period_capture_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // measurement state mirrored by the predictor
   logic [47:0] rise_at, fall_at, cycle_begin, active_at;
   logic [31:0] low_span, high_span, rise_span, on_sum, on_prev, offset_span, cycle_span;
   logic [31:0] edges_seen, stale_limit;
   logic [15:0] rev_seen;

   rsp_item_type measurements_q[$];
   int          failures;
   int          items_sent;
   int          results_checked;
   int          quiet_cycles;
   bit          moved;

   bit          send_gaps;
   bit          rsp_gaps;
   bit          hold_req;
   int          hold_len;

   logic [47:0] cursor_ts;
   logic [15:0] cursor_rev;
   bit          line_high;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] clamp_span(input logic [47:0] d);
      return (d[47:32] != 16'd0) ? 32'hFFFF_FFFF : d[31:0];
   endfunction

   function automatic logic [31:0] elapsed(input logic [47:0] later, input logic [47:0] earlier);
      logic [47:0] d;
      d = later - earlier;
      return clamp_span(d);
   endfunction

   function automatic void clear_capture();
      rise_at     = '0;
      fall_at     = '0;
      cycle_begin = '0;
      active_at   = '0;
      low_span    = '0;
      high_span   = '0;
      rise_span   = '0;
      on_sum      = '0;
      on_prev     = '0;
      offset_span = '0;
      cycle_span  = '0;
      edges_seen  = '0;
      rev_seen    = '0;
      stale_limit = TIMEOUT_AT_RESET;
   endfunction

   function automatic rsp_item_type advance_capture(input req_item_type it);
      rsp_item_type r;
      logic [32:0]  total;
      logic [31:0]  w;
      logic [47:0]  idle_for;
      case (it.req_type)
         REQ_RISE: begin
            edges_seen = edges_seen + 32'd1;
            active_at  = it.timestamp_us;
            low_span   = elapsed(it.timestamp_us, fall_at);
            rise_span  = elapsed(it.timestamp_us, rise_at);
            rise_at    = it.timestamp_us;
         end
         REQ_FALL: begin
            edges_seen = edges_seen + 32'd1;
            active_at  = it.timestamp_us;
            w          = elapsed(it.timestamp_us, rise_at);
            high_span  = w;
            total      = {1'b0, on_sum} + {1'b0, w};
            on_sum     = total[32] ? 32'hFFFF_FFFF : total[31:0];
            if (rev_seen != it.revolution_count) begin
               rev_seen    = it.revolution_count;
               on_prev     = on_sum;
               on_sum      = '0;
               offset_span = elapsed(it.timestamp_us, cycle_begin);
            end
            fall_at = it.timestamp_us;
         end
         REQ_TRIG: begin
            if (it.trigger_index == 8'd0) begin
               cycle_span  = elapsed(it.timestamp_us, cycle_begin);
               cycle_begin = it.timestamp_us;
            end
         end
         default: begin
         end
      endcase
      idle_for                 = it.timestamp_us - active_at;
      r.low_width_us           = low_span;
      r.high_width_us          = high_span;
      r.period_us              = rise_span;
      r.total_on_prev_cycle_us = on_prev;
      r.wave_offset_us         = offset_span;
      r.cycle_duration_us      = cycle_span;
      r.event_count            = edges_seen;
      r.signal_stale           = (idle_for > {16'd0, stale_limit});
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic void compare_measurements(input rsp_item_type want, input rsp_item_type got);
      check_field("low_width_us", want.low_width_us, got.low_width_us);
      check_field("high_width_us", want.high_width_us, got.high_width_us);
      check_field("period_us", want.period_us, got.period_us);
      check_field("total_on_prev_cycle_us", want.total_on_prev_cycle_us,
                  got.total_on_prev_cycle_us);
      check_field("wave_offset_us", want.wave_offset_us, got.wave_offset_us);
      check_field("cycle_duration_us", want.cycle_duration_us, got.cycle_duration_us);
      check_field("event_count", want.event_count, got.event_count);
      check_field("signal_stale", {31'd0, want.signal_stale}, {31'd0, got.signal_stale});
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_capture();
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (csr_we) begin
            stale_limit = csr_wdata;
         end
         if (req_valid && !req_stall) begin
            measurements_q.push_back(advance_capture(req_item));
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (measurements_q.size() == 0) begin
               $error("result with no item outstanding");
               failures++;
            end else begin
               compare_measurements(measurements_q.pop_front(), rsp_item);
               results_checked++;
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // receiver: random stall bursts, or one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall = 1'b1;
            repeat (hold_len) @(negedge clock);
            rsp_stall = 1'b0;
            hold_req  = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall = 1'b0;
         end
         @(negedge clock);
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("pulse_width_period_capture_core: mismatch");
      $finish;
   end

   function automatic req_item_type make_item(input req_kind_type kind, input logic [47:0] ts,
                                              input logic [15:0] rev, input logic [7:0] idx);
      req_item_type it;
      it.req_type         = kind;
      it.timestamp_us     = ts;
      it.revolution_count = rev;
      it.trigger_index    = idx;
      return it;
   endfunction

   // enter and leave at a falling edge; valid stays high after acceptance
   task automatic send_item(input req_item_type it);
      if (send_gaps && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_item  = it;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (measurements_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [31:0] value);
      drain_results();
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic test_directed_cases();
      send_item(make_item(REQ_QUERY, 48'd0, 16'd0, 8'd0));
      send_item(make_item(REQ_QUERY, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 8'hFF));
      send_item(make_item(REQ_RISE, 48'd100, 16'd0, 8'd0));
      send_item(make_item(REQ_FALL, 48'h1_0000_0064, 16'd0, 8'd0));
      send_item(make_item(REQ_FALL, 48'h2_0000_0000, 16'd0, 8'd0));
      send_item(make_item(REQ_FALL, 48'h3_0000_0000, 16'hFFFF, 8'd0));
      send_item(make_item(REQ_TRIG, 48'd5000, 16'd0, 8'd0));
      send_item(make_item(REQ_TRIG, 48'd6000, 16'd0, 8'hFF));
      send_item(make_item(REQ_TRIG, 48'd7000, 16'd0, 8'd1));
      send_item(make_item(REQ_TRIG, 48'd9000, 16'd0, 8'd0));
      send_item(make_item(REQ_RISE, 48'd10000, 16'd0, 8'd0));
      send_item(make_item(REQ_FALL, 48'd10500, 16'd1, 8'd0));
      send_item(make_item(REQ_RISE, 48'd8000, 16'd1, 8'd0));
      send_item(make_item(REQ_FALL, 48'hFFFF_FFFF_FF00, 16'd1, 8'd0));
      send_item(make_item(REQ_RISE, 48'h40, 16'd1, 8'd0));
      send_item(make_item(REQ_FALL, 48'h80, 16'd2, 8'd0));
      send_item(make_item(REQ_QUERY, 48'h80 + 48'd4_000_000, 16'd2, 8'd0));
      send_item(make_item(REQ_QUERY, 48'h80 + 48'd4_000_001, 16'd2, 8'd0));
      send_item(make_item(REQ_TRIG, 48'hFFFF_FFFF_FFFF, 16'd2, 8'd0));
      send_item(make_item(REQ_TRIG, 48'd10, 16'd2, 8'd0));
      send_item(make_item(REQ_RISE, 48'd0, 16'hFFFF, 8'hFF));
      send_item(make_item(REQ_FALL, 48'd0, 16'd0, 8'd0));
      cursor_ts  = 48'd0;
      cursor_rev = 16'd0;
      line_high  = 1'b0;
   endtask

   task automatic run_capture_traffic(input int count);
      req_item_type it;
      int           pick;
      logic [47:0]  step;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 19))
            0:       step = 48'({$urandom, $urandom});
            1:       step = 48'($urandom);
            2:       step = 48'd0 - 48'($urandom_range(1, 1000));
            default: step = 48'($urandom_range(0, 3000));
         endcase
         cursor_ts = cursor_ts + step;
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            if (line_high && $urandom_range(0, 3) == 0) cursor_rev = cursor_rev + 16'd1;
            it = make_item(line_high ? REQ_FALL : REQ_RISE, cursor_ts, cursor_rev, 8'd0);
            line_high = !line_high;
         end else if (pick < 80) begin
            it = make_item(REQ_TRIG, cursor_ts, cursor_rev,
                           ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255)) : 8'd0);
         end else if (pick < 90) begin
            it = make_item(REQ_QUERY, cursor_ts, cursor_rev, 8'($urandom));
         end else begin
            it = make_item(req_kind_type'(2'($urandom_range(0, 3))), 48'({$urandom, $urandom}),
                           16'($urandom), 8'($urandom));
         end
         send_item(it);
      end
   endtask

   task automatic test_timeout_settings();
      logic [31:0] settings[4];
      settings[0] = 32'd1;
      settings[1] = 32'hFFFF_FFFF;
      settings[2] = 32'd1000;
      settings[3] = $urandom;
      foreach (settings[k]) begin
         write_timeout(settings[k]);
         run_capture_traffic(280);
      end
   endtask

   task automatic test_input_backpressure();
      write_timeout(TIMEOUT_AT_RESET);
      send_gaps = 1'b0;
      hold_len  = 200;
      hold_req  = 1'b1;
      run_capture_traffic(80);
      send_gaps = 1'b1;
      run_capture_traffic(150);
   endtask

   task automatic test_steady_stream();
      write_timeout(32'd50_000);
      send_gaps = 1'b0;
      rsp_gaps  = 1'b0;
      run_capture_traffic(300);
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_item   = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      failures   = 0;
      items_sent = 0;
      results_checked = 0;
      quiet_cycles    = 0;
      send_gaps  = 1'b1;
      rsp_gaps   = 1'b1;
      hold_req   = 1'b0;
      hold_len   = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_timeout_settings();
      test_input_backpressure();
      test_steady_stream();

      drain_results();
      repeat (6) @(posedge clock);
      $display("Sent %0d items and compared %0d results: edges, triggers, queries, noise,",
               items_sent, results_checked);
      $display("time wrap, saturation, six stale timeouts and a long output hold-off.");
      if (failures == 0) begin
         $display("pulse_width_period_capture_core: match");
      end else begin
         $display("pulse_width_period_capture_core: mismatch");
      end
      $finish;
   end

endmodule
